// ----- hw/rtl/tmie_pkg.sv -----
// Shared types and constants for the tape machine instruction executor.
package tmie_pkg;

    localparam logic [7:0] CMD_RIGHT = 8'h3E;
    localparam logic [7:0] CMD_LEFT  = 8'h3C;
    localparam logic [7:0] CMD_INC   = 8'h2B;
    localparam logic [7:0] CMD_DEC   = 8'h2D;
    localparam logic [7:0] CMD_OUT   = 8'h2E;
    localparam logic [7:0] CMD_IN    = 8'h2C;
    localparam logic [7:0] CMD_OPEN  = 8'h5B;
    localparam logic [7:0] CMD_CLOSE = 8'h5D;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNMATCHED  = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_STACK_FULL = 3'd3;
    localparam logic [2:0] ST_TAPE_END   = 3'd4;
    localparam logic [2:0] ST_UNBALANCED = 3'd5;
    localparam logic [2:0] ST_HALTED     = 3'd6;

    localparam logic ACT_EXEC = 1'b0;

    typedef struct packed {
        logic [2:0] status;
        logic       halt_set;
        logic       emit_valid;
        logic [7:0] emit_byte;
        logic       console_taken;
        logic       jump;
        logic       cell_we;
        logic [7:0] cell_value;
        logic       push;
        logic       pop;
    } exec_ctl_t;

endpackage

// ----- hw/rtl/tmie_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tmie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tmie_exec.sv -----
// Command decode and execute logic for one registered request.
module tmie_exec (
    input  logic                  halted,
    input  logic                  action,
    input  logic [7:0]            cmd,
    input  logic [7:0]            console_byte,
    input  logic                  console_valid,
    input  logic [7:0]            cell_data,
    input  logic                  ptr_last,
    input  logic                  stack_empty,
    input  logic                  stack_full,
    output tmie_pkg::exec_ctl_t   ctl
);

    always_comb begin
        ctl = '0;
        ctl.status = tmie_pkg::ST_OK;
        if (halted) begin
            ctl.status = tmie_pkg::ST_HALTED;
        end else if (action != tmie_pkg::ACT_EXEC) begin
            if (!stack_empty) begin
                ctl.status = tmie_pkg::ST_UNBALANCED;
            end
        end else begin
            unique case (cmd)
                tmie_pkg::CMD_RIGHT: begin
                    if (ptr_last) begin
                        ctl.status = tmie_pkg::ST_TAPE_END;
                    end
                end
                tmie_pkg::CMD_INC: begin
                    ctl.cell_we    = 1'b1;
                    ctl.cell_value = cell_data + 8'd1;
                end
                tmie_pkg::CMD_DEC: begin
                    ctl.cell_we    = 1'b1;
                    ctl.cell_value = cell_data - 8'd1;
                end
                tmie_pkg::CMD_OUT: begin
                    ctl.emit_valid = 1'b1;
                    ctl.emit_byte  = cell_data;
                end
                tmie_pkg::CMD_IN: begin
                    if (console_valid) begin
                        ctl.cell_we       = 1'b1;
                        ctl.cell_value    = console_byte;
                        ctl.console_taken = 1'b1;
                    end else begin
                        ctl.status = tmie_pkg::ST_EXHAUSTED;
                    end
                end
                tmie_pkg::CMD_OPEN: begin
                    if (stack_full) begin
                        ctl.status = tmie_pkg::ST_STACK_FULL;
                    end else begin
                        ctl.push = 1'b1;
                    end
                end
                tmie_pkg::CMD_CLOSE: begin
                    if (stack_empty) begin
                        ctl.status = tmie_pkg::ST_UNMATCHED;
                    end else if (cell_data == 8'd0) begin
                        ctl.pop = 1'b1;
                    end else begin
                        ctl.jump = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        ctl.halt_set = (ctl.status != tmie_pkg::ST_OK) && (ctl.status != tmie_pkg::ST_HALTED);
    end

endmodule

// ----- hw/rtl/tape_machine_instruction_executor_top.sv -----
// Top level of the tape machine instruction executor: pipeline, tape and loop stack.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | action, program_byte, after_position,
//          |           |                   | console_byte, console_valid
//  m_      | out       | m_valid / m_ready | emit_valid, emit_byte, console_taken,
//          |           |                   | jump_request, jump_target, status
//
// One request per cycle is accepted unless a stalled result or the tape clear holds s_ready
// low; each request is registered into the execute stage, its result into the m_ registers.
// The tape RAM and the stack RAM are read at accept and written when the request
// leaves the execute stage, with a one-entry bypass between neighbors.
// After reset the tape is cleared, one cell a cycle, with s_ready low until every cell is zero.
// A stalled result holds the execute stage, which in turn holds s_ready low.
module tape_machine_instruction_executor_top #(
    parameter int TAPE_CELLS    = 4096,
    parameter int LOOP_DEPTH    = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_program_byte,
    input  logic [15:0] s_after_position,
    input  logic [7:0]  s_console_byte,
    input  logic        s_console_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_emit_valid,
    output logic [7:0]  m_emit_byte,
    output logic        m_console_taken,
    output logic        m_jump_request,
    output logic [15:0] m_jump_target,
    output logic [2:0]  m_status
);

    localparam int PTR_W = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int SA_W  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOOP_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPE_CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LOOP_DEPTH);

    logic                     clearing_reg;
    logic [PTR_W-1:0]         clr_addr_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [PTR_W-1:0]         ptr_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     halted_reg;

    logic                     s1_valid_reg;
    logic                     s1_action_reg;
    logic [7:0]               s1_cmd_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;
    logic [7:0]               s1_cbyte_reg;
    logic                     s1_cvalid_reg;
    logic [PTR_W-1:0]         s1_ptr_reg;
    logic                     cell_fwd_reg;
    logic [7:0]               cell_fwd_data_reg;
    logic                     stk_fwd_reg;
    logic [POSITION_BITS-1:0] stk_fwd_data_reg;

    logic                     m_valid_reg;
    logic                     m_emit_valid_reg;
    logic [7:0]               m_emit_byte_reg;
    logic                     m_console_taken_reg;
    logic                     m_jump_request_reg;
    logic [15:0]              m_jump_target_reg;
    logic [2:0]               m_status_reg;

    logic                     s_accept;
    logic                     s1_adv;
    logic [7:0]               tape_rd;
    logic [7:0]               cell_val;
    logic [POSITION_BITS-1:0] stk_rd;
    logic [POSITION_BITS-1:0] stk_top;
    logic                     tape_we;
    logic [PTR_W-1:0]         tape_waddr;
    logic [7:0]               tape_wdata;
    logic                     stk_we;
    logic [SA_W-1:0]          stk_raddr;
    tmie_pkg::exec_ctl_t      ex;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;

    assign cell_val = cell_fwd_reg ? cell_fwd_data_reg : tape_rd;
    assign stk_top  = stk_fwd_reg ? stk_fwd_data_reg : stk_rd;

    tmie_exec u_exec (
        .halted        (halted_reg),
        .action        (s1_action_reg),
        .cmd           (s1_cmd_reg),
        .console_byte  (s1_cbyte_reg),
        .console_valid (s1_cvalid_reg),
        .cell_data     (cell_val),
        .ptr_last      (s1_ptr_reg == PTR_LAST),
        .stack_empty   (cnt_reg == '0),
        .stack_full    (cnt_reg == CNT_FULL),
        .ctl           (ex)
    );

    always_comb begin
        ptr_next = ptr_reg;
        if (s_accept && s_action == tmie_pkg::ACT_EXEC) begin
            if (s_program_byte == tmie_pkg::CMD_RIGHT && ptr_reg != PTR_LAST) begin
                ptr_next = ptr_reg + 1'b1;
            end else if (s_program_byte == tmie_pkg::CMD_LEFT && ptr_reg != '0) begin
                ptr_next = ptr_reg - 1'b1;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (s1_adv && ex.push) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (s1_adv && ex.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign stk_raddr  = SA_W'(cnt_next - 1'b1);
    assign stk_we     = s1_adv && ex.push;
    assign tape_we    = clearing_reg || (s1_adv && ex.cell_we);
    assign tape_waddr = clearing_reg ? clr_addr_reg : s1_ptr_reg;
    assign tape_wdata = clearing_reg ? 8'd0 : ex.cell_value;

    tmie_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .aclk  (aclk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (s_accept),
        .raddr (ptr_reg),
        .rdata (tape_rd)
    );

    tmie_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (LOOP_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (SA_W'(cnt_reg)),
        .wdata (s1_pos_reg),
        .re    (s_accept),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            halted_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == PTR_LAST) begin
                    clearing_reg <= 1'b0;
                end
            end
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
            if (s1_adv && ex.halt_set) begin
                halted_reg <= 1'b1;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg     <= s_action;
            s1_cmd_reg        <= s_program_byte;
            s1_pos_reg        <= POSITION_BITS'(s_after_position);
            s1_cbyte_reg      <= s_console_byte;
            s1_cvalid_reg     <= s_console_valid;
            s1_ptr_reg        <= ptr_reg;
            cell_fwd_reg      <= s1_adv && ex.cell_we && (s1_ptr_reg == ptr_reg);
            cell_fwd_data_reg <= ex.cell_value;
            stk_fwd_reg       <= s1_adv && ex.push;
            stk_fwd_data_reg  <= s1_pos_reg;
        end
        if (s1_adv) begin
            m_emit_valid_reg    <= ex.emit_valid;
            m_emit_byte_reg     <= ex.emit_byte;
            m_console_taken_reg <= ex.console_taken;
            m_jump_request_reg  <= ex.jump;
            m_jump_target_reg   <= ex.jump ? 16'(stk_top) : 16'd0;
            m_status_reg        <= ex.status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_emit_valid    = m_emit_valid_reg;
    assign m_emit_byte     = m_emit_byte_reg;
    assign m_console_taken = m_console_taken_reg;
    assign m_jump_request  = m_jump_request_reg;
    assign m_jump_target   = m_jump_target_reg;
    assign m_status        = m_status_reg;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && halted_reg |-> ex.status == tmie_pkg::ST_HALTED)
        else $error("Request executed after halt.");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("Loop stack count above depth.");

    a_jump_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && ex.jump |-> cnt_reg != '0)
        else $error("Jump requested with an empty loop stack.");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_accept && !s1_valid_reg)
        else $error("Request taken while the tape is being cleared.");

endmodule
